>>> src/sorted_key_table_macros.svh
// Assertion macros shared by the sorted key table RTL.
// No dependencies; taken in by files that carry concurrent checks.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SKT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted key table check failed");

// Next-cycle implication, disabled during reset.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted key table check failed");

`endif

>>> src/skt_pkg.sv
// Types and constants for the sorted key table.
// No dependencies; used by sorted_key_table.
package skt_pkg;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int PAY_W    = 32;
   localparam int RANK_W   = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STS_BAD_RANK  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_PUT,
      ST_DONE
   } state_type;

endpackage

>>> src/skt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; used by sorted_key_table.
module skt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/sorted_key_table.sv
// Sorted key table: up to CAPACITY records kept in ascending key order in one RAM.
// Insert and delete run a scan that reads one RAM entry per cycle and writes back
// the shifted one.
// One request is worked at a time; the next is taken while the result waits in rsp regs.
// Reset clears the record count and the handshake; RAM contents are left as they are.
`include "sorted_key_table_macros.svh"

module sorted_key_table #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [skt_pkg::CMD_W-1:0]          req_command,
   input  logic signed [skt_pkg::KEY_W-1:0]   req_key,
   input  logic [skt_pkg::PAY_W-1:0]          req_payload,
   input  logic [skt_pkg::RANK_W-1:0]         req_rank,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [skt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [skt_pkg::COUNT_W-1:0]        rsp_count,
   output logic signed [skt_pkg::KEY_W-1:0]   rsp_out_key,
   output logic [skt_pkg::PAY_W-1:0]          rsp_out_payload
);
   import skt_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int RW   = CW + RANK_W;
   localparam int RECW = KEY_W + PAY_W;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0]        pay_ff, pay_in;
   logic [RANK_W-1:0]       rank_ff, rank_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic                    found_ff, found_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic signed [KEY_W-1:0] res_key_ff, res_key_in;
   logic [PAY_W-1:0]        res_pay_ff, res_pay_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic signed [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [PAY_W-1:0]        rsp_pay_ff, rsp_pay_in;

   logic                    wr_en, rd_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [RECW-1:0]         wr_data, rd_data;
   logic signed [KEY_W-1:0] rd_key;
   logic [PAY_W-1:0]        rd_pay;
   logic                    key_ge, key_eq, scan_last;
   logic                    go_scan, go_put, go_done, rsp_load;

   skt_ram #(
      .WIDTH (RECW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key    = rd_data[RECW-1 -: KEY_W];
   assign rd_pay    = rd_data[PAY_W-1:0];
   assign key_ge    = rd_key >= key_ff;
   assign key_eq    = rd_key == key_ff;
   assign scan_last = CW'(ptr_ff) == CW'(count_ff - CW'(1));

   assign req_ready = state_ff == ST_IDLE;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = go_scan ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            priority if (go_put) begin
               state_in = ST_PUT;
            end else if (go_done) begin
               state_in = ST_DONE;
            end
         end
         ST_PUT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and RAM control
   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      rank_in       = rank_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = {key_ff, pay_ff};
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;
      go_scan       = 1'b0;
      go_put        = 1'b0;
      go_done       = 1'b0;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               key_in        = req_key;
               pay_in        = req_payload;
               rank_in       = req_rank;
               found_in      = 1'b0;
               res_status_in = STS_OK;
               res_key_in    = '0;
               res_pay_in    = '0;
            end
         end
         ST_START: begin
            unique case (cmd_ff)
               CMD_INSERT: begin
                  priority if (count_ff == CW'(CAPACITY)) begin
                     res_status_in = STS_FULL;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     count_in = CW'(count_ff + CW'(1));
                  end else begin
                     // scan downwards from the top entry
                     rd_en   = 1'b1;
                     rd_addr = AW'(count_ff - CW'(1));
                     ptr_in  = AW'(count_ff - CW'(1));
                     go_scan = 1'b1;
                  end
               end
               CMD_DELETE: begin
                  if (count_ff == '0) begin
                     res_status_in = STS_EMPTY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = '0;
                     ptr_in  = '0;
                     go_scan = 1'b1;
                  end
               end
               CMD_READ: begin
                  if (RW'(rank_ff) >= RW'(count_ff)) begin
                     res_status_in = STS_BAD_RANK;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(rank_ff);
                     ptr_in  = AW'(rank_ff);
                     go_scan = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            unique case (cmd_ff)
               CMD_INSERT: begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(ptr_ff + AW'(1));
                  if (key_ge) begin
                     // shift this entry up one place
                     wr_data = rd_data;
                     if (ptr_ff == '0) begin
                        go_put = 1'b1;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(ptr_ff - AW'(1));
                        ptr_in  = AW'(ptr_ff - AW'(1));
                     end
                  end else begin
                     count_in = CW'(count_ff + CW'(1));
                     go_done  = 1'b1;
                  end
               end
               CMD_DELETE: begin
                  // once found, every later entry moves down one place
                  if (found_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(ptr_ff - AW'(1));
                     wr_data = rd_data;
                  end else if (key_eq) begin
                     found_in   = 1'b1;
                     res_key_in = rd_key;
                     res_pay_in = rd_pay;
                  end
                  if (scan_last) begin
                     go_done = 1'b1;
                     if (found_ff || key_eq) begin
                        count_in = CW'(count_ff - CW'(1));
                     end else begin
                        res_status_in = STS_NOT_FOUND;
                     end
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(ptr_ff + AW'(1));
                     ptr_in  = AW'(ptr_ff + AW'(1));
                  end
               end
               CMD_READ: begin
                  res_key_in = rd_key;
                  res_pay_in = rd_pay;
                  go_done    = 1'b1;
               end
               default: begin
                  go_done = 1'b1;
               end
            endcase
         end
         ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = CW'(count_ff + CW'(1));
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_key_in    = res_key_ff;
               rsp_pay_in    = res_pay_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      rank_ff       <= rank_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_pay_ff;

   `SKT_ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `SKT_ASSERT_IMPL(a_no_wr_idle, clock, reset, state_ff == ST_IDLE || state_ff == ST_DONE, !wr_en)
   `SKT_ASSERT_NEXT(a_scan_has_data, clock, reset, state_in == ST_SCAN, rd_en == 1'b0 || state_ff == ST_SCAN)
   `SKT_ASSERT_NEXT(a_load_then_valid, clock, reset, rsp_load, rsp_valid && state_ff == ST_IDLE)

endmodule

>>> sim/tb_sorted_key_table.sv
// Testbench for sorted_key_table: directed and random requests checked against a local
// model of the sorted record table, with random idling on both handshakes.
// Depends on skt_pkg and the sorted_key_table RTL.
`timescale 1ns / 1ps

module tb_sorted_key_table;
   import skt_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = CAPACITY + 8;

   // the block treats command 3 as a no-op
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFFFFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [COUNT_W-1:0]      count;
      logic signed [KEY_W-1:0] rec_key;
      logic [PAY_W-1:0]        rec_payload;
   } table_reply_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command = '0;
   logic signed [KEY_W-1:0]  req_key = '0;
   logic [PAY_W-1:0]         req_payload = '0;
   logic [RANK_W-1:0]        req_rank = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [COUNT_W-1:0]       rsp_count;
   logic signed [KEY_W-1:0]  rsp_out_key;
   logic [PAY_W-1:0]         rsp_out_payload;

   // local copy of the table, in sorted order
   logic signed [KEY_W-1:0]  held_keys[$];
   logic [PAY_W-1:0]         held_payloads[$];
   table_reply_type          owed_replies[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  hold_cycles = 0;
   bit  idle_on = 1'b1;

   sorted_key_table #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_key(req_key),
      .req_payload(req_payload),
      .req_rank(req_rank),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_out_key(rsp_out_key),
      .rsp_out_payload(rsp_out_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_sorted_key_table failed");
         $finish;
      end
   end

   // Applies one request to the local table and returns the reply it should produce.
   function automatic table_reply_type apply_table_op(input logic [CMD_W-1:0] cmd,
                                                      input logic signed [KEY_W-1:0] key,
                                                      input logic [PAY_W-1:0] pay,
                                                      input logic [RANK_W-1:0] rank);
      table_reply_type r;
      int pos;
      r = '0;
      r.status = STS_OK;
      case (cmd)
         CMD_INSERT: begin
            if (held_keys.size() >= CAPACITY) begin
               r.status = STS_FULL;
            end else begin
               // before the first record whose key is equal or greater
               pos = held_keys.size();
               for (int i = held_keys.size() - 1; i >= 0; i--)
                  if (held_keys[i] >= key) pos = i;
               held_keys.insert(pos, key);
               held_payloads.insert(pos, pay);
            end
         end
         CMD_DELETE: begin
            if (held_keys.size() == 0) begin
               r.status = STS_EMPTY;
            end else begin
               pos = -1;
               for (int i = held_keys.size() - 1; i >= 0; i--)
                  if (held_keys[i] == key) pos = i;
               if (pos < 0) begin
                  r.status = STS_NOT_FOUND;
               end else begin
                  r.rec_key = held_keys[pos];
                  r.rec_payload = held_payloads[pos];
                  held_keys.delete(pos);
                  held_payloads.delete(pos);
               end
            end
         end
         CMD_READ: begin
            if (rank >= held_keys.size()) begin
               r.status = STS_BAD_RANK;
            end else begin
               r.rec_key = held_keys[rank];
               r.rec_payload = held_payloads[rank];
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(held_keys.size());
      return r;
   endfunction

   // Keys drawn so that duplicates, extremes and present keys come up often.
   function automatic logic signed [KEY_W-1:0] pick_key();
      logic signed [KEY_W-1:0] k;
      case ($urandom_range(0, 3))
         0: k = $urandom;
         1: k = $signed($urandom_range(0, 6)) - 3;
         2: begin
            case ($urandom_range(0, 3))
               0: k = KEY_MAX;
               1: k = KEY_MIN;
               2: k = '0;
               default: k = -1;
            endcase
         end
         default: begin
            if (held_keys.size() != 0) k = held_keys[$urandom_range(0, held_keys.size() - 1)];
            else k = $urandom;
         end
      endcase
      return k;
   endfunction

   // Drives one request and waits for it to be taken; the reply is predicted on acceptance.
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic signed [KEY_W-1:0] key,
                               input logic [PAY_W-1:0] pay,
                               input logic [RANK_W-1:0] rank);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_key     <= key;
      req_payload <= pay;
      req_rank    <= rank;
      do @(posedge clock); while (!req_ready);
      owed_replies.push_back(apply_table_op(cmd, key, pay, rank));
   endtask

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (hold_cycles == 0 && idle_on && $urandom_range(0, 5) == 0)
         hold_cycles = $urandom_range(1, 13);
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      table_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected reply: status %0d count %0d key %0d payload %h",
                        rsp_status, rsp_count, rsp_out_key, rsp_out_payload);
         end else begin
            want = owed_replies.pop_front();
            if (rsp_status !== want.status || rsp_count !== want.count ||
                rsp_out_key !== want.rec_key || rsp_out_payload !== want.rec_payload) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("reply mismatch: expected status %0d count %0d key %0d payload %h",
                           want.status, want.count, want.rec_key, want.rec_payload);
                  $display("                got status %0d count %0d key %0d payload %h",
                           rsp_status, rsp_count, rsp_out_key, rsp_out_payload);
               end
            end
         end
      end
   end

   task automatic test_empty_table();
      send_request(CMD_DELETE, 5, '0, '0);
      send_request(CMD_READ, '0, '0, '0);
      send_request(CMD_UNUSED, -1, '1, 4'hF);
   endtask

   task automatic test_key_extremes();
      send_request(CMD_INSERT, KEY_MAX, 32'hFFFF_FFFF, '0);
      send_request(CMD_INSERT, KEY_MIN, 32'h0000_0000, '0);
      send_request(CMD_INSERT, '0, 32'h3F80_0000, '0);
      // duplicate key lands ahead of the existing one
      send_request(CMD_INSERT, '0, 32'hBF80_0000, '0);
      send_request(CMD_INSERT, -1, 32'h7F80_0000, '0);
      for (int r = 0; r <= 5; r++)
         send_request(CMD_READ, '0, '0, RANK_W'(r));
      send_request(CMD_READ, '0, '0, 4'hF);
      send_request(CMD_DELETE, 12345, '0, '0);
      send_request(CMD_DELETE, '0, '0, '0);
      send_request(CMD_DELETE, KEY_MIN, '0, '0);
      send_request(CMD_DELETE, KEY_MAX, '0, '0);
      send_request(CMD_UNUSED, KEY_MIN, 32'h8000_0001, 4'h9);
   endtask

   // Fill to capacity and past it, read around, then drain by key to empty.
   task automatic test_fill_and_drain(input int rounds);
      int extra;
      for (int n = 0; n < rounds; n++) begin
         extra = $urandom_range(1, 3);
         for (int i = 0; i < CAPACITY + extra; i++)
            send_request(CMD_INSERT, pick_key(), $urandom, RANK_W'($urandom_range(0, 15)));
         repeat ($urandom_range(2, 5))
            send_request(CMD_READ, $urandom, $urandom, RANK_W'($urandom_range(0, 15)));
         while (held_keys.size() != 0) begin
            if ($urandom_range(0, 9) != 0)
               send_request(CMD_DELETE, held_keys[$urandom_range(0, held_keys.size() - 1)],
                            $urandom, RANK_W'($urandom_range(0, 15)));
            else
               send_request(CMD_DELETE, $urandom, $urandom, RANK_W'($urandom_range(0, 15)));
         end
         send_request(CMD_DELETE, pick_key(), $urandom, RANK_W'($urandom_range(0, 15)));
      end
   endtask

   task automatic test_random_mix(input int items);
      logic [CMD_W-1:0]  cmd;
      logic [RANK_W-1:0] rank;
      for (int n = 0; n < items; n++) begin
         if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
         cmd = CMD_W'($urandom_range(0, 3));
         if (held_keys.size() != 0 && $urandom_range(0, 1) == 0)
            rank = RANK_W'($urandom_range(0, held_keys.size() - 1));
         else
            rank = RANK_W'($urandom_range(0, 15));
         send_request(cmd, pick_key(), $urandom, rank);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_key_extremes();
      test_fill_and_drain(5);
      test_random_mix(220);
      idle_on = 1'b0;
      test_random_mix(80);

      req_valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && owed_replies.size() == 0)
         $display("tb_sorted_key_table passed");
      else
         $display("tb_sorted_key_table failed");
      $finish;
   end

endmodule
